/* design/adc_ladder_key_debouncer_macros.svh */
// assertion helpers shared by the debouncer modules
// every macro expects clk and arst_n in scope
`ifndef ADC_LADDER_KEY_DEBOUNCER_MACROS_SVH
`define ADC_LADDER_KEY_DEBOUNCER_MACROS_SVH

// plain property checked on every edge outside reset
`define ALKD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ALKD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

`endif

/* design/alkd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alkd_pkg
// Shared types and constants of the resistor ladder key debouncer.
// ----------------------------------------------------------------------------
package alkd_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int VALUE_W    = 8;
	localparam int NUM_LEVELS = 7;
	localparam int KEY_W      = 3;
	localparam int NUM_KEYS   = 7;
	localparam int KEY_CHANNEL = 6;
	localparam int SEARCH_KEYS = (NUM_KEYS < NUM_LEVELS) ? NUM_KEYS : NUM_LEVELS;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int HIST_W     = 4;

	localparam logic [HIST_W-1:0] HIST_FULL = 4'hF;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_WINDOW = 3'd7;

	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	localparam logic [NUM_LEVELS-1:0][SAMPLE_W-1:0] LEVEL_RESET = {
		12'd3503, 12'd3306, 12'd3026, 12'd2584, 12'd1910, 12'd949, 12'd7
	};
	localparam logic [SAMPLE_W-1:0] WINDOW_RESET = 12'd100;

	typedef struct packed {
		logic [NUM_LEVELS-1:0][SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0]                 window;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [VALUE_W-1:0] value;
	} result_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DEBOUNCE,
		PH_PRESSED
	} phase_t;

endpackage

/* design/alkd_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alkd_regs
// APB register file: seven key levels and the match half window.
// ----------------------------------------------------------------------------
module alkd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [alkd_pkg::ADDR_W-1:0] paddr,
	input  logic [alkd_pkg::DATA_W-1:0] pwdata,
	output logic [alkd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output alkd_pkg::cfg_t              cfg
);
	import alkd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{level: LEVEL_RESET, window: WINDOW_RESET};
		end else if (wr) begin
			if (idx == REG_WINDOW) begin
				cfg_q.window <= pwdata[SAMPLE_W-1:0];
			end else begin
				cfg_q.level[idx] <= pwdata[SAMPLE_W-1:0];
			end
		end
	end

	always_comb begin
		if (idx == REG_WINDOW) begin
			prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_q.window};
		end else begin
			prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_q.level[idx]};
		end
	end

endmodule

/* design/alkd_track.sv */
`timescale 1ns / 1ps
`include "adc_ladder_key_debouncer_macros.svh"
// ----------------------------------------------------------------------------
// alkd_track
// Key search, press debounce with timeout, and release debounce.
// ----------------------------------------------------------------------------
module alkd_track #(
	parameter int PRESS_TIMEOUT = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [alkd_pkg::SAMPLE_W-1:0] sample,
	input  alkd_pkg::cfg_t                cfg,
	output alkd_pkg::result_t             res
);
	import alkd_pkg::*;

	localparam int CntW = $clog2(PRESS_TIMEOUT + 2);

	phase_t            state_q, state_d;
	logic [KEY_W-1:0]  key_q, key_d, first_key;
	logic [HIST_W-1:0] hist_q, hist_d, hist_dbn, hist_rel;
	logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
	logic              found, match, timeout;
	logic [VALUE_W-1:0] value;

	// open interval lvl - w < s < lvl + w, no wrap
	function automatic logic in_window(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] lvl,
			logic [SAMPLE_W-1:0] w);
		logic [SAMPLE_W:0] s_up;
		logic [SAMPLE_W:0] l_up;
		s_up = {1'b0, s} + {1'b0, w};
		l_up = {1'b0, lvl} + {1'b0, w};
		return (s_up > {1'b0, lvl}) && ({1'b0, s} < l_up);
	endfunction

	// lowest matching key wins
	always_comb begin
		found     = 1'b0;
		first_key = '0;
		for (int k = SEARCH_KEYS - 1; k >= 0; k--) begin
			if (in_window(sample, cfg.level[k], cfg.window)) begin
				found     = 1'b1;
				first_key = KEY_W'(k);
			end
		end
	end

	assign match    = in_window(sample, cfg.level[key_q], cfg.window);
	assign hist_dbn = {hist_q[HIST_W-2:0], match};
	assign hist_rel = {hist_q[HIST_W-2:0], ~match};
	assign cnt_inc  = cnt_q + CntW'(1);
	assign timeout  = cnt_inc > CntW'(PRESS_TIMEOUT);
	assign value    = {4'(KEY_CHANNEL), 1'b0, key_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_IDLE: begin
				if (step && found) state_d = PH_DEBOUNCE;
			end
			PH_DEBOUNCE: begin
				if (step) begin
					if (timeout) state_d = PH_IDLE;
					else if (hist_dbn == HIST_FULL) state_d = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (step && hist_rel == HIST_FULL) state_d = PH_IDLE;
			end
			default: state_d = PH_IDLE;
		endcase
	end

	always_comb begin
		key_d  = key_q;
		hist_d = hist_q;
		cnt_d  = cnt_q;
		res    = '{valid: 1'b0, kind: EV_PRESS, value: value};
		unique case (state_q)
			PH_IDLE: begin
				// the finding sample is also the first debounce sample
				if (step && found) begin
					key_d  = first_key;
					hist_d = HIST_W'(1);
					cnt_d  = CntW'(1);
				end
			end
			PH_DEBOUNCE: begin
				if (step) begin
					if (timeout) begin
						key_d  = '0;
						hist_d = '0;
						cnt_d  = '0;
					end else if (hist_dbn == HIST_FULL) begin
						hist_d    = '0;
						cnt_d     = '0;
						res.valid = 1'b1;
					end else begin
						hist_d = hist_dbn;
						cnt_d  = cnt_inc;
					end
				end
			end
			PH_PRESSED: begin
				if (step) begin
					if (hist_rel == HIST_FULL) begin
						key_d     = '0;
						hist_d    = '0;
						res.valid = 1'b1;
						res.kind  = EV_RELEASE;
					end else begin
						hist_d = hist_rel;
					end
				end
			end
			default: begin
				key_d  = '0;
				hist_d = '0;
				cnt_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			key_q   <= '0;
			hist_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			key_q   <= key_d;
			hist_q  <= hist_d;
			cnt_q   <= cnt_d;
		end
	end

	`ALKD_ASSERT_IMPL(a_idle_clean, state_q == PH_IDLE,
		hist_q == '0 && cnt_q == '0 && key_q == '0, "tracking state not cleared in idle")
	`ALKD_ASSERT(a_cnt_bound, cnt_q <= CntW'(PRESS_TIMEOUT), "debounce count past timeout")
	`ALKD_ASSERT_IMPL(a_event_src, res.valid, step && state_q != PH_IDLE,
		"event raised without a sample in a tracking phase")
	`ALKD_ASSERT_IMPL(a_pressed_cnt, state_q == PH_PRESSED, cnt_q == '0,
		"count running while pressed")

endmodule

/* design/adc_ladder_key_debouncer.sv */
`timescale 1ns / 1ps
`include "adc_ladder_key_debouncer_macros.svh"
// ----------------------------------------------------------------------------
// adc_ladder_key_debouncer
// Resistor ladder keypad decoder with press and release debounce.
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid/in_ready carries one 12-bit sample per item
// - output channel out_valid/out_ready carries event_kind (0 press,
//   1 release) and event_value (channel * 16 + key index)
// - most samples give no event; at most one event per sample
// - APB port sets the seven key levels and the match half window;
//   write it only while no sample is in flight
// - an event reaches the outputs through the input register, which holds its
//   sample, and then the result register
// - throughput: one sample per cycle unless stalled; search, debounce and
//   state update all fit in the single stage between input and result register
// - if the receiver stalls, the result register holds; the input register
//   still takes one more sample, then in_ready drops until the event is taken
// - reset clears the tracking state, empties both registers and restores
//   the default levels and window
// ----------------------------------------------------------------------------
module adc_ladder_key_debouncer #(
	parameter int PRESS_TIMEOUT = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [alkd_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          event_kind,
	output logic [alkd_pkg::VALUE_W-1:0]  event_value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [alkd_pkg::ADDR_W-1:0]   paddr,
	input  logic [alkd_pkg::DATA_W-1:0]   pwdata,
	output logic [alkd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import alkd_pkg::*;

	cfg_t                cfg;
	result_t             res;
	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                adv;
	logic                out_valid_q;
	logic                event_kind_q;
	logic [VALUE_W-1:0]  event_value_q;

	alkd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	alkd_track #(
		.PRESS_TIMEOUT (PRESS_TIMEOUT)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_valid_q & adv),
		.sample (sample_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// the stage moves when the result register is free or being emptied
	assign adv      = ~out_valid_q | out_ready;
	assign in_ready = ~s1_valid_q | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) sample_s1 <= sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q & res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q && res.valid) begin
			event_kind_q  <= res.kind;
			event_value_q <= res.value;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = event_kind_q;
	assign event_value = event_value_q;

	`ALKD_ASSERT(a_s1_hold, s1_valid_q && !adv |=> s1_valid_q && $stable(sample_s1),
		"stalled sample lost from input register")
	`ALKD_ASSERT(a_s1_fill, in_valid && in_ready |=> s1_valid_q,
		"accepted item not in input register")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ladder key debouncer against a cycle-free model of its press,
// release and timeout behavior, with random stalls on both channels and
// several key level and window settings loaded over the APB port.
// ----------------------------------------------------------------------------
module testbench;
	import alkd_pkg::*;

	localparam int PRESS_TIMEOUT = 32;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
	} key_event_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic                event_kind;
	logic [VALUE_W-1:0]  event_value;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// model copy of the configuration and the tracking state
	logic [SAMPLE_W-1:0] level_q [NUM_LEVELS];
	logic [SAMPLE_W-1:0] window_q;
	logic                key_held;
	logic                cand_valid;
	logic [KEY_W-1:0]    cand_key;
	logic [HIST_W-1:0]   hist_q;
	int                  tick_count;

	key_event_t pending_events[$];
	int         err_count   = 0;
	int         items_sent  = 0;
	int         cycle_count = 0;
	int         idle_pct    = 0;
	int         stall_pct   = 0;

	adc_ladder_key_debouncer #(
		.PRESS_TIMEOUT(PRESS_TIMEOUT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.event_value(event_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic bit in_window(input logic [SAMPLE_W-1:0] s,
			input logic [SAMPLE_W-1:0] lvl);
		int si, li, wi;
		si = int'(s);
		li = int'(lvl);
		wi = int'(window_q);
		return (si > li - wi) && (si < li + wi);
	endfunction

	function automatic void drop_candidate();
		cand_valid = 1'b0;
		cand_key   = '0;
		hist_q     = '0;
		tick_count = 0;
	endfunction

	// returns 1 when the sample completes a press or a release
	function automatic bit advance_debouncer(input logic [SAMPLE_W-1:0] s,
			output logic kind, output logic [VALUE_W-1:0] value);
		int k;
		bit hit;
		kind  = EV_PRESS;
		value = '0;
		if (key_held) begin
			hit    = in_window(s, level_q[cand_key]);
			hist_q = {hist_q[HIST_W-2:0], !hit};
			if (hist_q == HIST_FULL) begin
				kind     = EV_RELEASE;
				value    = VALUE_W'(KEY_CHANNEL * 16) | VALUE_W'(cand_key);
				key_held = 1'b0;
				drop_candidate();
				return 1'b1;
			end
			return 1'b0;
		end
		if (!cand_valid) begin
			k = 0;
			while (k < SEARCH_KEYS && !in_window(s, level_q[k]))
				k++;
			if (k >= SEARCH_KEYS)
				return 1'b0;
			cand_valid = 1'b1;
			cand_key   = KEY_W'(k);
		end
		hit        = in_window(s, level_q[cand_key]);
		hist_q     = {hist_q[HIST_W-2:0], hit};
		tick_count = tick_count + 1;
		if (tick_count > PRESS_TIMEOUT) begin
			// timeout wins even over a completed history
			drop_candidate();
			return 1'b0;
		end
		if (hist_q == HIST_FULL) begin
			hist_q     = '0;
			tick_count = 0;
			key_held   = 1'b1;
			kind       = EV_PRESS;
			value      = VALUE_W'(KEY_CHANNEL * 16) | VALUE_W'(cand_key);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("%s", msg);
	endtask

	// results are checked before the new item is predicted
	always @(posedge clk) begin
		key_event_t want;
		logic       kind;
		logic [VALUE_W-1:0] value;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					flag_error($sformatf("unexpected event kind %0d value 0x%0h",
						event_kind, event_value));
				end else begin
					want = pending_events.pop_front();
					if (event_kind !== want.kind)
						flag_error($sformatf("event_kind: expected %0d got %0d",
							want.kind, event_kind));
					if (event_value !== want.value)
						flag_error($sformatf("event_value: expected 0x%0h got 0x%0h",
							want.value, event_value));
				end
			end
			if (in_valid && in_ready) begin
				if (advance_debouncer(sample, kind, value))
					pending_events.push_back('{kind: kind, value: value});
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// lets every item in flight finish before the port is touched
	task automatic settle();
		in_valid <= 1'b0;
		// wait for the next edge so the last accepted item is already predicted
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [SAMPLE_W-1:0] val);
		logic [DATA_W-1:0] word;
		word = $urandom;
		word[SAMPLE_W-1:0] = val;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WINDOW)
			window_q = val;
		else
			level_q[idx] = val;
	endtask

	function automatic logic [SAMPLE_W-1:0] near_level(input int k);
		int lo, hi;
		if (window_q == 0)
			return SAMPLE_W'($urandom);
		lo = int'(level_q[k]) - int'(window_q) + 1;
		hi = int'(level_q[k]) + int'(window_q) - 1;
		if (lo < 0)
			lo = 0;
		if (hi > SAMPLE_MAX)
			hi = SAMPLE_MAX;
		return SAMPLE_W'($urandom_range(hi, lo));
	endfunction

	function automatic logic [SAMPLE_W-1:0] far_level(input int k);
		logic [SAMPLE_W-1:0] s;
		s = '0;
		repeat (32) begin
			s = SAMPLE_W'($urandom);
			if (!in_window(s, level_q[k]))
				return s;
		end
		return s;
	endfunction

	// one press and release attempt on key k, with bounce and rare slow presses
	task automatic key_stroke(input int k);
		int presses, holds, lets, near_pct;
		near_pct = 90;
		presses  = $urandom_range(8, 3);
		if ($urandom_range(19) == 0) begin
			presses  = $urandom_range(45, 30);
			near_pct = 50;
		end
		holds = $urandom_range(6);
		lets  = $urandom_range(7, 3);
		repeat (presses)
			send_sample(($urandom_range(99) < near_pct) ? near_level(k) : far_level(k));
		repeat (holds)
			send_sample(near_level(k));
		repeat (lets)
			send_sample(($urandom_range(99) < 88) ? far_level(k) : near_level(k));
	endtask

	task automatic run_strokes(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(99) < 80)
				key_stroke($urandom_range(NUM_LEVELS - 1));
			else
				repeat ($urandom_range(4, 1)) send_sample(SAMPLE_W'($urandom));
		end
		settle();
	endtask

	task automatic pick_random_levels();
		for (int k = 0; k < NUM_LEVELS; k++)
			write_reg(reg_idx_t'(k), SAMPLE_W'($urandom));
		write_reg(REG_WINDOW, SAMPLE_W'($urandom_range(250, 1)));
	endtask

	task automatic test_press_release_extremes();
		repeat (4) send_sample('0);
		// bounce while held: three misses then a hit
		repeat (3) send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample('0);
		repeat (4) send_sample(SAMPLE_W'(SAMPLE_MAX));
		repeat (4) send_sample(level_q[6]);
		repeat (4) send_sample('0);
		settle();
	endtask

	task automatic test_press_timeout();
		// found on the first item, then a late full history hits the timeout
		send_sample(level_q[3]);
		repeat (28) send_sample(level_q[0]);
		repeat (4) send_sample(level_q[3]);
		repeat (4) send_sample(level_q[3]);
		repeat (4) send_sample(level_q[0]);
		settle();
	endtask

	task automatic test_zero_window();
		write_reg(REG_WINDOW, '0);
		for (int k = 0; k < NUM_LEVELS; k++)
			repeat (4) send_sample(level_q[k]);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		settle();
		write_reg(REG_WINDOW, WINDOW_RESET);
	endtask

	task automatic test_full_window();
		// every sample matches key 0, so a press always comes
		write_reg(REG_WINDOW, SAMPLE_W'(SAMPLE_MAX));
		repeat (5) send_sample(SAMPLE_W'($urandom));
		settle();
		write_reg(REG_WINDOW, WINDOW_RESET);
		repeat (4) send_sample(far_level(0));
		settle();
	endtask

	task automatic test_edge_levels();
		write_reg(reg_idx_t'(0), '0);
		write_reg(reg_idx_t'(6), SAMPLE_W'(SAMPLE_MAX));
		write_reg(REG_WINDOW, SAMPLE_W'(1));
		repeat (4) send_sample('0);
		repeat (4) send_sample(SAMPLE_W'(1));
		repeat (4) send_sample(SAMPLE_W'(SAMPLE_MAX));
		repeat (4) send_sample(SAMPLE_W'(SAMPLE_MAX - 1));
		settle();
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		sample   <= '0;
		out_ready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		for (int k = 0; k < NUM_LEVELS; k++)
			level_q[k] = LEVEL_RESET[k];
		window_q = WINDOW_RESET;
		key_held = 1'b0;
		drop_candidate();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 23;
		stall_pct = 79;
		test_press_release_extremes();
		test_press_timeout();
		test_zero_window();
		test_full_window();
		test_edge_levels();
		run_strokes(250);

		idle_pct  = 79;
		stall_pct = 23;
		pick_random_levels();
		run_strokes(250);

		idle_pct  = 0;
		stall_pct = 0;
		pick_random_levels();
		run_strokes(250);

		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* adc_ladder_key_debouncer.f */
+incdir+design
design/alkd_pkg.sv
design/alkd_regs.sv
design/alkd_track.sv
design/adc_ladder_key_debouncer.sv
verif/testbench.sv
